[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the sorted priority queue.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define SMPQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define SMPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/smpq_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Sizes, command and error codes, transaction payloads and cell control.
// ----------------------------------------------------------------------------
package smpq_pkg;

  // Number of cells, one stored value per cell.
  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int COUNT_FIELD_W = 5;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_POP_EMPTY = 2'd1,
    ERR_PUSH_FULL = 2'd2
  } err_t;

  // Per-cell operation broadcast along the row.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_POP
  } cell_op_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] top_value;
    logic [COUNT_FIELD_W-1:0] count;
    logic                     is_empty;
    err_t                     error;
  } out_t;

  typedef struct packed {
    cell_op_t                 op;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

[src/smpq_cell.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry, compares it with the broadcast value and shifts with its
// neighbors on push and pop.
// ----------------------------------------------------------------------------
module smpq_cell (
  input  logic                             clk,
  input  smpq_pkg::cell_ctrl_t             ctrl,
  input  logic                             occupied,
  input  logic                             left_lt,
  input  logic signed [smpq_pkg::DATA_W-1:0] left_entry,
  input  logic signed [smpq_pkg::DATA_W-1:0] right_entry,
  output logic                             lt,
  output logic signed [smpq_pkg::DATA_W-1:0] entry
);

  logic signed [smpq_pkg::DATA_W-1:0] entry_next;

  // The entry sorts ahead of the new value when it is stored and smaller.
  assign lt = occupied && (entry < ctrl.value);

  // Keep, insert the new value, or take a neighbor's entry.
  always_comb begin
    entry_next = entry;
    unique case (ctrl.op)
      smpq_pkg::CELL_PUSH: begin
        if (lt) begin
          entry_next = entry;
        end else if (left_lt) begin
          entry_next = ctrl.value;
        end else begin
          entry_next = left_entry;
        end
      end
      smpq_pkg::CELL_POP: begin
        entry_next = right_entry;
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

[src/sorted_min_priority_queue.sv]
// ----------------------------------------------------------------------------
// Sorted minimum priority queue
// Row of compare-and-shift cells keeping signed values in ascending order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_ready / in_data carries a command (push,
//   pop, clear) and a value. Output channel out_valid / out_ready / out_data
//   returns one status transaction per command: the smallest value (zero
//   when empty), the count, an empty flag and an error code.
//   All cells compare against the broadcast value and shift on the same
//   edge, so the row of DEPTH cells sets no extra latency. The status
//   appears in the output register in the cycle after acceptance, and one
//   command can be taken every cycle while the output is not stalled.
//   A command is accepted while the output register is empty or is being
//   drained in the same cycle; when the receiver stalls, the result holds
//   and in_ready drops until it is taken.
//   Reset empties the queue and the output register. Pop on an empty queue
//   reports error 1; push on a full queue drops the value with error 2.
//   Command code 3 changes nothing and reports the status with no error.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_min_priority_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  smpq_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output smpq_pkg::out_t out_data
);

  logic                               in_acc;
  logic [smpq_pkg::CNT_W-1:0]         count;
  logic [smpq_pkg::CNT_W-1:0]         count_next;
  smpq_pkg::err_t                     err;
  smpq_pkg::cell_ctrl_t               ctrl;
  logic signed [smpq_pkg::DATA_W-1:0] head_next;
  logic                               is_full;
  logic                               is_zero;

  logic signed [smpq_pkg::DATA_W-1:0] entries [smpq_pkg::DEPTH+1];
  logic                               lts     [smpq_pkg::DEPTH+1];
  logic                               occ     [smpq_pkg::DEPTH];

  assign in_ready = !out_valid || out_ready;
  assign in_acc   = in_valid && in_ready;
  assign is_full  = (count == smpq_pkg::CNT_W'(smpq_pkg::DEPTH));
  assign is_zero  = (count == '0);

  // Decode the command into a cell operation, new count and error.
  always_comb begin
    ctrl.op    = smpq_pkg::CELL_HOLD;
    ctrl.value = in_data.value;
    count_next = count;
    err        = smpq_pkg::ERR_OK;
    if (in_acc) begin
      unique case (in_data.cmd)
        smpq_pkg::CMD_PUSH: begin
          if (is_full) begin
            err = smpq_pkg::ERR_PUSH_FULL;
          end else begin
            ctrl.op    = smpq_pkg::CELL_PUSH;
            count_next = count + smpq_pkg::CNT_W'(1);
          end
        end
        smpq_pkg::CMD_POP: begin
          if (is_zero) begin
            err = smpq_pkg::ERR_POP_EMPTY;
          end else begin
            ctrl.op    = smpq_pkg::CELL_POP;
            count_next = count - smpq_pkg::CNT_W'(1);
          end
        end
        smpq_pkg::CMD_CLEAR: begin
          count_next = '0;
        end
        default: begin
          count_next = count;
        end
      endcase
    end
  end

  // The head cell's value after this command, for the status transaction.
  always_comb begin
    unique case (ctrl.op)
      smpq_pkg::CELL_PUSH: head_next = lts[1] ? entries[0] : in_data.value;
      smpq_pkg::CELL_POP:  head_next = entries[1];
      default:             head_next = entries[0];
    endcase
  end

  // The row of cells; the left end always admits an insertion.
  assign lts[0] = 1'b1;
  assign entries[smpq_pkg::DEPTH] = entries[smpq_pkg::DEPTH-1];

  for (genvar g = 0; g < smpq_pkg::DEPTH; g++) begin : g_cell
    logic signed [smpq_pkg::DATA_W-1:0] left_entry;

    assign occ[g] = (smpq_pkg::CNT_W'(g) < count);
    if (g == 0) begin : g_first
      assign left_entry = in_data.value;
    end else begin : g_rest
      assign left_entry = entries[g-1];
    end

    smpq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (occ[g]),
      .left_lt     (lts[g]),
      .left_entry  (left_entry),
      .right_entry (entries[g+1]),
      .lt          (lts[g+1]),
      .entry       (entries[g])
    );
  end

  // Count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Output register for the status transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data.top_value <= (count_next == '0) ? '0 : head_next;
      out_data.count     <= smpq_pkg::COUNT_FIELD_W'(count_next);
      out_data.is_empty  <= (count_next == '0);
      out_data.error     <= err;
    end
  end

  // Checks on the count and the reported status.
  `SMPQ_ASSERT_IMPL(a_count_bound, 1'b1, count <= smpq_pkg::CNT_W'(smpq_pkg::DEPTH), "count above depth")
  `SMPQ_ASSERT_NEXT(a_push_grows, in_acc && in_data.cmd == smpq_pkg::CMD_PUSH && !is_full, count == $past(count) + smpq_pkg::CNT_W'(1), "push did not grow count")
  `SMPQ_ASSERT_IMPL(a_pop_empty_flag, out_valid && out_data.error == smpq_pkg::ERR_POP_EMPTY, out_data.is_empty && out_data.top_value == '0, "empty pop status wrong")

endmodule
